/* rtl/core/hrlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request line parser package
// Shared types, codes and register indexes for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int unsigned MethodW   = 8;
    localparam int unsigned UriW      = 12;
    localparam int unsigned ProtoW    = 8;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 12;
    localparam int unsigned TdataW    = 48;

    localparam logic [ByteW-1:0] CharSpace = 8'h20;
    localparam logic [ByteW-1:0] CharCr    = 8'h0D;
    localparam logic [ByteW-1:0] CharLf    = 8'h0A;
    localparam logic [ByteW-1:0] CharTab   = 8'h09;

    localparam logic [MethodW-1:0] MethodLimitReset = 8'd10;
    localparam logic [UriW-1:0]    UriLimitReset    = 12'd25;
    localparam logic [ProtoW-1:0]  ProtoLimitReset  = 8'd10;

    typedef enum logic [CfgIndexW-1:0] {
        REG_METHOD_LIMIT = 2'd0,
        REG_URI_LIMIT    = 2'd1,
        REG_PROTO_LIMIT  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_METHOD = 2'd0,
        PH_URI    = 2'd1,
        PH_PROTO  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_DONE     = 2'd1,
        ST_BAD      = 2'd2,
        ST_URI_LONG = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        K_NONE        = 3'd0,
        K_SPACE       = 3'd1,
        K_CR_ALONE    = 3'd2,
        K_LF_ALONE    = 3'd3,
        K_TAB         = 3'd4,
        K_METHOD_LONG = 3'd5,
        K_URI_LONG    = 3'd6,
        K_PROTO_LONG  = 3'd7
    } fault_t;

    typedef enum logic [1:0] {
        TAG_NONE   = 2'd0,
        TAG_METHOD = 2'd1,
        TAG_URI    = 2'd2,
        TAG_PROTO  = 2'd3
    } field_tag_t;

    typedef struct packed {
        phase_t             phase;
        logic               cr_pending;
        logic [MethodW-1:0] method_count;
        logic [UriW-1:0]    uri_count;
        logic [ProtoW-1:0]  protocol_count;
        outcome_t           outcome;
        fault_t             fault;
    } parse_state_t;

    typedef struct packed {
        logic [MethodW-1:0] method_limit;
        logic [UriW-1:0]    uri_limit;
        logic [ProtoW-1:0]  protocol_limit;
    } limits_t;

    localparam parse_state_t StateClear = '{
        phase:          PH_METHOD,
        cr_pending:     1'b0,
        method_count:   '0,
        uri_count:      '0,
        protocol_count: '0,
        outcome:        ST_BUSY,
        fault:          K_NONE
    };

endpackage

/* rtl/core/http_request_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request line parser
// Splits a request line into method, URI and protocol, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request byte per word in s_tdata, s_tuser[0] set to
//   restart the parser before that byte. m_ channel: one result word per
//   input word, with the field tag in m_tuser and the echoed byte, status,
//   error code and running field lengths in m_tdata.
//   cfg channel: writes the method, URI and protocol length limits; write
//   only while no word is in flight. cfg_ready is always high.
//   Result: the result word is registered when the byte is taken.
//   Throughput: one byte per cycle while m_tready is high, set by the single
//   compare-and-count step between the parser state register and the result register.
//   Reset: limits return to 10, 25 and 10, the parser returns to the method
//   field with all counts cleared, and the result register empties.
//   Stall: while m_tready is low the result holds; one more byte is not
//   taken until the held result leaves, so s_tready follows m_tready.
// ----------------------------------------------------------------------------
module http_request_line_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: [7:0] data_byte
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    // s_tuser: [0] restart
    input  logic [0:0]                        s_tuser,
    // m_tdata: [7:0] byte_out, [9:8] status, [12:10] error_kind,
    //          [20:13] method_length, [32:21] uri_length, [40:33] protocol_length
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hrlp_pkg::TdataW-1:0]       m_tdata,
    // m_tuser: [1:0] field_tag
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hrlp_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [hrlp_pkg::CfgDataW-1:0]     cfg_data
);

    hrlp_pkg::limits_t      limits_reg;
    hrlp_pkg::parse_state_t state_reg;
    hrlp_pkg::parse_state_t state_next;
    hrlp_pkg::field_tag_t   tag_next;
    logic                   m_tvalid_reg;
    logic [hrlp_pkg::TdataW-1:0] m_tdata_reg;
    logic [hrlp_pkg::TdataW-1:0] m_tdata_next;
    logic [1:0]             m_tuser_reg;
    logic                   s_accept;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    hrlp_step u_step (
        .cur_state  (state_reg),
        .limits     (limits_reg),
        .data_byte  (s_tdata),
        .restart    (s_tuser[0]),
        .next_state (state_next),
        .field_tag  (tag_next)
    );

    assign m_tdata_next = {
        7'd0,
        state_next.protocol_count,
        state_next.uri_count,
        state_next.method_count,
        state_next.fault,
        state_next.outcome,
        s_tdata
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.method_limit   <= hrlp_pkg::MethodLimitReset;
            limits_reg.uri_limit      <= hrlp_pkg::UriLimitReset;
            limits_reg.protocol_limit <= hrlp_pkg::ProtoLimitReset;
        end else if (cfg_valid && cfg_ready) begin
            unique case (hrlp_pkg::reg_index_t'(cfg_index))
                hrlp_pkg::REG_METHOD_LIMIT:
                    limits_reg.method_limit <= cfg_data[hrlp_pkg::MethodW-1:0];
                hrlp_pkg::REG_URI_LIMIT:
                    limits_reg.uri_limit <= cfg_data[hrlp_pkg::UriW-1:0];
                hrlp_pkg::REG_PROTO_LIMIT:
                    limits_reg.protocol_limit <= cfg_data[hrlp_pkg::ProtoW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hrlp_pkg::StateClear;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= tag_next;
        end
    end

endmodule

/* rtl/core/hrlp_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request line parser step
// Next parser state and field tag for one byte, given the current state.
// ----------------------------------------------------------------------------
module hrlp_step (
    input  hrlp_pkg::parse_state_t      cur_state,
    input  hrlp_pkg::limits_t           limits,
    input  logic [hrlp_pkg::ByteW-1:0]  data_byte,
    input  logic                        restart,
    output hrlp_pkg::parse_state_t      next_state,
    output hrlp_pkg::field_tag_t        field_tag
);

    hrlp_pkg::parse_state_t base;

    always_comb begin
        base       = restart ? hrlp_pkg::StateClear : cur_state;
        next_state = base;
        field_tag  = hrlp_pkg::TAG_NONE;

        if (base.outcome == hrlp_pkg::ST_BUSY) begin
            if (base.cr_pending) begin
                next_state.cr_pending = 1'b0;
                if (data_byte == hrlp_pkg::CharLf) begin
                    next_state.outcome = hrlp_pkg::ST_DONE;
                end else begin
                    next_state.outcome = hrlp_pkg::ST_BAD;
                    next_state.fault   = hrlp_pkg::K_CR_ALONE;
                end
            end else if (data_byte == hrlp_pkg::CharSpace) begin
                if (base.phase == hrlp_pkg::PH_METHOD && base.method_count != '0) begin
                    next_state.phase = hrlp_pkg::PH_URI;
                end else if (base.phase != hrlp_pkg::PH_PROTO && base.uri_count != '0) begin
                    next_state.phase = hrlp_pkg::PH_PROTO;
                end else begin
                    next_state.outcome = hrlp_pkg::ST_BAD;
                    next_state.fault   = hrlp_pkg::K_SPACE;
                end
            end else if (data_byte == hrlp_pkg::CharCr) begin
                next_state.cr_pending = 1'b1;
            end else if (data_byte == hrlp_pkg::CharLf) begin
                next_state.outcome = hrlp_pkg::ST_BAD;
                next_state.fault   = hrlp_pkg::K_LF_ALONE;
            end else if (data_byte == hrlp_pkg::CharTab) begin
                next_state.outcome = hrlp_pkg::ST_BAD;
                next_state.fault   = hrlp_pkg::K_TAB;
            end else begin
                unique case (base.phase)
                    hrlp_pkg::PH_METHOD: begin
                        if (base.method_count >= limits.method_limit) begin
                            next_state.outcome = hrlp_pkg::ST_BAD;
                            next_state.fault   = hrlp_pkg::K_METHOD_LONG;
                        end else begin
                            next_state.method_count = base.method_count + 8'd1;
                            field_tag = hrlp_pkg::TAG_METHOD;
                        end
                    end
                    hrlp_pkg::PH_URI: begin
                        if (base.uri_count >= limits.uri_limit) begin
                            next_state.outcome = hrlp_pkg::ST_URI_LONG;
                            next_state.fault   = hrlp_pkg::K_URI_LONG;
                        end else begin
                            next_state.uri_count = base.uri_count + 12'd1;
                            field_tag = hrlp_pkg::TAG_URI;
                        end
                    end
                    default: begin
                        if (base.protocol_count >= limits.protocol_limit) begin
                            next_state.outcome = hrlp_pkg::ST_BAD;
                            next_state.fault   = hrlp_pkg::K_PROTO_LONG;
                        end else begin
                            next_state.protocol_count = base.protocol_count + 8'd1;
                            field_tag = hrlp_pkg::TAG_PROTO;
                        end
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/core/hrlp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request line parser checker
// Port-level checks on result words, bound to the parser top level.
// ----------------------------------------------------------------------------
module hrlp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [hrlp_pkg::TdataW-1:0] m_tdata,
    input logic [1:0]                  m_tuser
);

    logic [1:0] status;
    logic [2:0] error_kind;

    assign status     = m_tdata[9:8];
    assign error_kind = m_tdata[12:10];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_tag_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != hrlp_pkg::TAG_NONE |-> status == hrlp_pkg::ST_BUSY)
        else $error("field byte tagged after parse finished");

    a_no_fault_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == hrlp_pkg::ST_BUSY || status == hrlp_pkg::ST_DONE)
        |-> error_kind == hrlp_pkg::K_NONE)
        else $error("error code set without error status");

    a_uri_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((status == hrlp_pkg::ST_URI_LONG) == (error_kind == hrlp_pkg::K_URI_LONG)))
        else $error("URI too long status and error code disagree");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* test/tb_http_request_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request line parser testbench
// Feeds request bytes as directed cases and as random well-formed and
// broken request lines under several length limits. Predicts every result
// word and checks it field by field, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_http_request_line_parser;
    import hrlp_pkg::*;

    localparam int unsigned WatchdogLimit = 4000;
    localparam int unsigned RandomItems   = 900;

    typedef struct packed {
        logic        restart;
        logic [7:0]  data;
    } req_byte_t;

    typedef struct packed {
        field_tag_t          tag;
        logic [ByteW-1:0]    data;
        outcome_t            status;
        fault_t              kind;
        logic [MethodW-1:0]  mlen;
        logic [UriW-1:0]     ulen;
        logic [ProtoW-1:0]   plen;
    } parse_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TdataW-1:0]     m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CfgIndexW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0]   cfg_data  = '0;

    http_request_line_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    req_byte_t      request_bytes_q[$];
    parse_result_t  line_results_q[$];
    int unsigned    items_sent   = 0;
    int unsigned    items_taken  = 0;
    int unsigned    fail_count   = 0;
    int unsigned    idle_cycles  = 0;
    logic           in_taken     = 1'b0;

    logic [MethodW-1:0]  lim_method;
    logic [UriW-1:0]     lim_uri;
    logic [ProtoW-1:0]   lim_proto;
    phase_t              st_phase;
    logic                st_cr;
    logic [MethodW-1:0]  st_mcount;
    logic [UriW-1:0]     st_ucount;
    logic [ProtoW-1:0]   st_pcount;
    outcome_t            st_outcome;
    fault_t              st_fault;

    function automatic void clear_parse_state();
        st_phase   = PH_METHOD;
        st_cr      = 1'b0;
        st_mcount  = '0;
        st_ucount  = '0;
        st_pcount  = '0;
        st_outcome = ST_BUSY;
        st_fault   = K_NONE;
    endfunction

    function automatic parse_result_t parse_request_byte(input logic [7:0] b, input logic rst);
        parse_result_t r;
        field_tag_t    tag;
        tag = TAG_NONE;
        if (rst) clear_parse_state();
        if (st_outcome == ST_BUSY) begin
            if (st_cr) begin
                st_cr = 1'b0;
                if (b == CharLf) begin
                    st_outcome = ST_DONE;
                end else begin
                    st_outcome = ST_BAD;
                    st_fault   = K_CR_ALONE;
                end
            end else if (b == CharSpace) begin
                if (st_phase == PH_METHOD && st_mcount != 0) begin
                    st_phase = PH_URI;
                end else if (st_phase != PH_PROTO && st_ucount != 0) begin
                    st_phase = PH_PROTO;
                end else begin
                    st_outcome = ST_BAD;
                    st_fault   = K_SPACE;
                end
            end else if (b == CharCr) begin
                st_cr = 1'b1;
            end else if (b == CharLf) begin
                st_outcome = ST_BAD;
                st_fault   = K_LF_ALONE;
            end else if (b == CharTab) begin
                st_outcome = ST_BAD;
                st_fault   = K_TAB;
            end else if (st_phase == PH_METHOD) begin
                if (32'(st_mcount) + 1 > 32'(lim_method)) begin
                    st_outcome = ST_BAD;
                    st_fault   = K_METHOD_LONG;
                end else begin
                    st_mcount = st_mcount + 8'd1;
                    tag = TAG_METHOD;
                end
            end else if (st_phase == PH_URI) begin
                if (32'(st_ucount) + 1 > 32'(lim_uri)) begin
                    st_outcome = ST_URI_LONG;
                    st_fault   = K_URI_LONG;
                end else begin
                    st_ucount = st_ucount + 12'd1;
                    tag = TAG_URI;
                end
            end else begin
                if (32'(st_pcount) + 1 > 32'(lim_proto)) begin
                    st_outcome = ST_BAD;
                    st_fault   = K_PROTO_LONG;
                end else begin
                    st_pcount = st_pcount + 8'd1;
                    tag = TAG_PROTO;
                end
            end
        end
        r.tag    = tag;
        r.data   = b;
        r.status = st_outcome;
        r.kind   = st_fault;
        r.mlen   = st_mcount;
        r.ulen   = st_ucount;
        r.plen   = st_pcount;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor: sample handshakes, keep the predicted results in order.
    always @(posedge aclk) begin
        parse_result_t want;
        if (!aresetn) begin
            in_taken   <= 1'b0;
            lim_method = MethodLimitReset;
            lim_uri    = UriLimitReset;
            lim_proto  = ProtoLimitReset;
            clear_parse_state();
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_METHOD_LIMIT: lim_method = cfg_data[MethodW-1:0];
                    REG_URI_LIMIT:    lim_uri    = cfg_data[UriW-1:0];
                    REG_PROTO_LIMIT:  lim_proto  = cfg_data[ProtoW-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                line_results_q.push_back(parse_request_byte(s_tdata, s_tuser[0]));
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (line_results_q.size() == 0) begin
                    $error("result word with no pending byte: m_tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = line_results_q.pop_front();
                    check_field("field_tag", want.tag, m_tuser);
                    check_field("byte_out", want.data, m_tdata[7:0]);
                    check_field("status", want.status, m_tdata[9:8]);
                    check_field("error_kind", want.kind, m_tdata[12:10]);
                    check_field("method_length", want.mlen, m_tdata[20:13]);
                    check_field("uri_length", want.ulen, m_tdata[32:21]);
                    check_field("protocol_length", want.plen, m_tdata[40:33]);
                end
            end
        end
    end

    // Driver: bursts of words with random gaps.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    req_byte_t   next_req;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // hold until taken
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (request_bytes_q.size() > 0) begin
            next_req = request_bytes_q.pop_front();
            s_tdata  <= next_req.data;
            s_tuser  <= next_req.restart;
            s_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 32);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Sink: random stall pattern that switches between modes.
    int unsigned sink_mode = 0;
    int unsigned sink_left = 0;
    int unsigned sink_tick = 0;

    always @(negedge aclk) begin
        if (sink_left == 0) begin
            sink_mode = $urandom_range(0, 3);
            sink_left = $urandom_range(20, 120);
        end
        sink_left--;
        sink_tick++;
        case (sink_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= sink_tick[2];
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] token_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CharSpace || c == CharCr || c == CharLf || c == CharTab)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic int pick_len(input int lim);
        int r;
        r = $urandom_range(0, 9);
        if (lim > 40) return $urandom_range(1, 8);
        if (r == 0) return lim + 1;
        if (r == 1) return lim;
        return $urandom_range(1, (lim < 12) ? lim : 12);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic rst);
        req_byte_t w;
        w.data    = b;
        w.restart = rst;
        request_bytes_q.push_back(w);
        items_sent++;
    endtask

    task automatic push_text(input string s, input logic rst_first);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], rst_first && i == 0);
    endtask

    task automatic push_request(input int mlen, input int ulen, input int plen,
                                input bit allow_faults);
        logic [7:0] line[$];
        logic [7:0] b;
        int         mode;
        int         pos;
        int         rst_pos;
        logic       first_rst;
        mode      = allow_faults ? $urandom_range(0, 9) : 0;
        rst_pos   = -1;
        first_rst = ($urandom_range(0, 19) != 0);
        for (int i = 0; i < mlen; i++) line.push_back(token_char());
        line.push_back(CharSpace);
        for (int i = 0; i < ulen; i++) line.push_back(token_char());
        line.push_back(CharSpace);
        for (int i = 0; i < plen; i++) line.push_back(token_char());
        line.push_back(CharCr);
        line.push_back(CharLf);
        pos = $urandom_range(0, line.size() - 3);
        case (mode)
            5: begin
                case ($urandom_range(0, 3))
                    0:       line[pos] = CharTab;
                    1:       line[pos] = CharLf;
                    2:       line[pos] = CharSpace;
                    default: line[pos] = CharCr;
                endcase
            end
            6: begin
                b = 8'($urandom_range(0, 255));
                if (b == CharLf) b = CharCr;
                line.insert(pos, CharCr);
                line.insert(pos + 1, b);
            end
            7: begin
                while (line.size() > pos + 1) void'(line.pop_back());
                line.push_back(CharCr);
                line.push_back(CharLf);
            end
            8: rst_pos = $urandom_range(1, line.size() - 1);
            9: begin
                repeat ($urandom_range(1, 4)) line.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        for (int i = 0; i < line.size(); i++)
            push_byte(line[i], (i == 0 && first_rst) || i == rst_pos);
    endtask

    task automatic write_limit(input reg_index_t idx, input logic [CfgDataW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (items_taken != items_sent || line_results_q.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    initial begin
        int unsigned random_start;
        int unsigned phase_start;
        int          m_lim;
        int          u_lim;
        int          p_lim;
        int          n;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed cases at the reset limits
        push_text("GET /", 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_text(" HTTP\r\n", 1'b0);
        push_text(" Z", 1'b1);
        push_text("\t", 1'b1);
        push_text("\n", 1'b1);
        push_text("\r\r", 1'b1);
        push_text("A\r\n", 1'b1);
        push_text("A  ", 1'b1);
        wait_drained();

        random_start = items_sent;
        n = 0;
        while (items_sent - random_start < RandomItems) begin
            case (n)
                0:       begin m_lim = 1;   u_lim = 1;    p_lim = 1;   end
                1:       begin m_lim = 255; u_lim = 4095; p_lim = 255; end
                2:       begin m_lim = 2;   u_lim = 3;    p_lim = 2;   end
                default: begin
                    m_lim = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 12);
                    u_lim = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(1, 20);
                    p_lim = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 12);
                end
            endcase
            write_limit(REG_URI_LIMIT, CfgDataW'(u_lim));
            write_limit(REG_METHOD_LIMIT, CfgDataW'(m_lim));
            write_limit(REG_PROTO_LIMIT, CfgDataW'(p_lim));
            phase_start = items_sent;
            while (items_sent - phase_start < 120)
                push_request(pick_len(m_lim), pick_len(u_lim), pick_len(p_lim), 1'b1);
            wait_drained();
            n++;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/hrlp_pkg.sv
rtl/core/hrlp_step.sv
rtl/core/http_request_line_parser.sv
rtl/core/hrlp_checker.sv
test/tb_http_request_line_parser.sv
